[hw/rtl/ccpp_pkg.sv]
// ----------------------------------------------------------------------------
// Constant pool parser package
// Shared tags, result kinds, error codes, the result record and tag decoding.
// ----------------------------------------------------------------------------
package ccpp_pkg;

	localparam logic [7:0] TAG_UTF8          = 8'd1;
	localparam logic [7:0] TAG_INTEGER       = 8'd3;
	localparam logic [7:0] TAG_FLOAT         = 8'd4;
	localparam logic [7:0] TAG_LONG          = 8'd5;
	localparam logic [7:0] TAG_DOUBLE        = 8'd6;
	localparam logic [7:0] TAG_CLASS         = 8'd7;
	localparam logic [7:0] TAG_STRING        = 8'd8;
	localparam logic [7:0] TAG_FIELDREF      = 8'd9;
	localparam logic [7:0] TAG_METHODREF     = 8'd10;
	localparam logic [7:0] TAG_IFACEREF      = 8'd11;
	localparam logic [7:0] TAG_NAMEANDTYPE   = 8'd12;
	localparam logic [7:0] TAG_METHODHANDLE  = 8'd15;
	localparam logic [7:0] TAG_METHODTYPE    = 8'd16;
	localparam logic [7:0] TAG_INVOKEDYNAMIC = 8'd18;

	localparam logic [1:0] KIND_ENTRY = 2'd0;
	localparam logic [1:0] KIND_UTF8  = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_BAD_TAG   = 2'd1;
	localparam logic [1:0] ERR_POOL_SIZE = 2'd2;

	localparam int TDATA_W = 136;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] slot;
		logic [7:0]  entry_tag;
		logic [15:0] first_index;
		logic [15:0] second_index;
		logic [63:0] raw_value;
		logic [7:0]  content_byte;
		logic [1:0]  error_code;
		logic        pool_last;
	} res_t;

	// Number of field bytes after the tag; zero marks an unknown tag.
	function automatic logic [3:0] field_len(input logic [7:0] tag);
		logic [3:0] len;
		begin
			case (tag) inside
				TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHODTYPE: len = 4'd2;
				TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
				TAG_IFACEREF, TAG_NAMEANDTYPE, TAG_INVOKEDYNAMIC: len = 4'd4;
				TAG_METHODHANDLE: len = 4'd3;
				TAG_LONG, TAG_DOUBLE: len = 4'd8;
				default: len = 4'd0;
			endcase
			return len;
		end
	endfunction

	function automatic logic two_slot(input logic [7:0] tag);
		return (tag == TAG_LONG) || (tag == TAG_DOUBLE);
	endfunction

endpackage

[hw/rtl/ccpp_in_stage.sv]
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted request until the parsing step takes it.
// ----------------------------------------------------------------------------
module ccpp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte[7:0]
	input  logic       s_tuser,   // start_req
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       start_s1
);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

endmodule

[hw/rtl/ccpp_step.sv]
// ----------------------------------------------------------------------------
// Parsing step
// Consumes one pool byte per step, updates the parser state and forms the
// result record that the byte causes, if any.
// ----------------------------------------------------------------------------
module ccpp_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      byte_s1,
	input  logic            start_s1,
	output logic            res_valid,
	output ccpp_pkg::res_t  res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_COUNT_LO,
		PH_TAG,
		PH_FIELDS,
		PH_UTF8
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] pool_size_q, pool_size_d;
	logic [15:0] slot_q, slot_d;
	logic [7:0]  tag_q, tag_d;
	logic [3:0]  fbc_q, fbc_d;
	logic [63:0] acc_q, acc_d;
	logic [15:0] utf8_rem_q, utf8_rem_d;

	logic [63:0] acc_next;
	logic [3:0]  fbc_next;
	logic [15:0] rem_next;
	logic [16:0] slot_fin;
	logic        fin_last;
	logic [16:0] slot_plus1;

	always_comb begin
		acc_next   = {acc_q[55:0], byte_s1};
		fbc_next   = fbc_q + 4'd1;
		rem_next   = utf8_rem_q - 16'd1;
		slot_fin   = {1'b0, slot_q} + (ccpp_pkg::two_slot(tag_q) ? 17'd2 : 17'd1);
		fin_last   = slot_fin >= {1'b0, pool_size_q};
		slot_plus1 = {1'b0, slot_q} + 17'd1;
	end

	always_comb begin
		phase_d     = phase_q;
		pool_size_d = pool_size_q;
		slot_d      = slot_q;
		tag_d       = tag_q;
		fbc_d       = fbc_q;
		acc_d       = acc_q;
		utf8_rem_d  = utf8_rem_q;
		res_valid   = 1'b0;
		res         = '0;

		if (start_s1) begin
			phase_d     = PH_COUNT_LO;
			pool_size_d = {byte_s1, 8'd0};
			slot_d      = 16'd1;
			tag_d       = '0;
			fbc_d       = '0;
			acc_d       = '0;
			utf8_rem_d  = '0;
		end else begin
			unique case (phase_q)
				PH_COUNT_LO: begin
					pool_size_d = {pool_size_q[15:8], byte_s1};
					slot_d      = 16'd1;
					if (pool_size_d == 16'd0) begin
						res_valid      = 1'b1;
						res.kind       = ccpp_pkg::KIND_ERROR;
						res.error_code = ccpp_pkg::ERR_POOL_SIZE;
						res.pool_last  = 1'b1;
						phase_d        = PH_IDLE;
					end else if (pool_size_d == 16'd1) begin
						res_valid     = 1'b1;
						res.kind      = ccpp_pkg::KIND_EMPTY;
						res.pool_last = 1'b1;
						phase_d       = PH_IDLE;
					end else begin
						phase_d = PH_TAG;
					end
				end
				PH_TAG: begin
					tag_d = byte_s1;
					if (ccpp_pkg::field_len(byte_s1) == 4'd0) begin
						res_valid      = 1'b1;
						res.kind       = ccpp_pkg::KIND_ERROR;
						res.slot       = slot_q;
						res.entry_tag  = byte_s1;
						res.error_code = ccpp_pkg::ERR_BAD_TAG;
						res.pool_last  = 1'b1;
						phase_d        = PH_IDLE;
					end else if (ccpp_pkg::two_slot(byte_s1) &&
							slot_plus1 >= {1'b0, pool_size_q}) begin
						res_valid      = 1'b1;
						res.kind       = ccpp_pkg::KIND_ERROR;
						res.slot       = slot_q;
						res.entry_tag  = byte_s1;
						res.error_code = ccpp_pkg::ERR_POOL_SIZE;
						res.pool_last  = 1'b1;
						phase_d        = PH_IDLE;
					end else begin
						fbc_d   = '0;
						acc_d   = '0;
						phase_d = PH_FIELDS;
					end
				end
				PH_FIELDS: begin
					acc_d = acc_next;
					fbc_d = fbc_next;
					if (fbc_next >= ccpp_pkg::field_len(tag_q)) begin
						res_valid     = 1'b1;
						res.kind      = ccpp_pkg::KIND_ENTRY;
						res.slot      = slot_q;
						res.entry_tag = tag_q;
						case (tag_q) inside
							ccpp_pkg::TAG_UTF8, ccpp_pkg::TAG_CLASS, ccpp_pkg::TAG_STRING,
							ccpp_pkg::TAG_METHODTYPE:
								res.first_index = acc_next[15:0];
							ccpp_pkg::TAG_INTEGER, ccpp_pkg::TAG_FLOAT:
								res.raw_value = {32'd0, acc_next[31:0]};
							ccpp_pkg::TAG_LONG, ccpp_pkg::TAG_DOUBLE:
								res.raw_value = acc_next;
							default: begin
								res.first_index  = acc_next[31:16];
								res.second_index = acc_next[15:0];
							end
						endcase
						if (tag_q == ccpp_pkg::TAG_UTF8 && acc_next[15:0] != 16'd0) begin
							utf8_rem_d = acc_next[15:0];
							phase_d    = PH_UTF8;
						end else begin
							if (tag_q == ccpp_pkg::TAG_UTF8) begin
								utf8_rem_d = '0;
							end
							slot_d        = slot_fin[15:0];
							res.pool_last = fin_last;
							phase_d       = fin_last ? PH_IDLE : PH_TAG;
						end
					end
				end
				PH_UTF8: begin
					res_valid        = 1'b1;
					res.kind         = ccpp_pkg::KIND_UTF8;
					res.slot         = slot_q;
					res.entry_tag    = tag_q;
					res.content_byte = byte_s1;
					utf8_rem_d       = rem_next;
					if (rem_next == 16'd0) begin
						slot_d        = slot_fin[15:0];
						res.pool_last = fin_last;
						phase_d       = fin_last ? PH_IDLE : PH_TAG;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pool_size_q <= '0;
			slot_q      <= 16'd1;
			tag_q       <= '0;
			fbc_q       <= '0;
			acc_q       <= '0;
			utf8_rem_q  <= '0;
		end else if (take) begin
			phase_q     <= phase_d;
			pool_size_q <= pool_size_d;
			slot_q      <= slot_d;
			tag_q       <= tag_d;
			fbc_q       <= fbc_d;
			acc_q       <= acc_d;
			utf8_rem_q  <= utf8_rem_d;
		end
	end

endmodule

[hw/rtl/ccpp_out_stage.sv]
// ----------------------------------------------------------------------------
// Result register
// Holds one result request for the output stream and packs its fields.
// ----------------------------------------------------------------------------
module ccpp_out_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           res_valid,
	input  ccpp_pkg::res_t                 res,
	input  logic                           step_valid,
	output logic                           room,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ccpp_pkg::TDATA_W-1:0]   m_tdata,
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast
);

	ccpp_pkg::res_t res_q;

	assign room = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (room) begin
			m_tvalid <= step_valid && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (room && step_valid && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tdata = {6'd0, res_q.error_code, res_q.content_byte, res_q.raw_value,
		res_q.second_index, res_q.first_index, res_q.entry_tag, res_q.slot};
	assign m_tuser = res_q.kind;
	assign m_tlast = res_q.pool_last;

endmodule

[hw/rtl/class_constant_pool_parser_unit.sv]
// Path: input register, parsing step (combinational), result register.
// Throughput: one byte per cycle; a stalled result register stalls the input.
// The rate is set by the single parsing step between input and result registers.
// Reset (arst_n low) returns the parser to idle, waiting for a start request,
// and empties both registers; bytes taken while idle give no result.
// ----------------------------------------------------------------------------
// Class-file constant pool parser
// Parses a big-endian constant pool into entry, Utf8, empty and error records.
// ----------------------------------------------------------------------------
module class_constant_pool_parser_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // data_byte[7:0]
	input  logic                         s_tuser,  // start_req
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// slot[15:0], entry_tag[23:16], first_index[39:24], second_index[55:40],
	// raw_value[119:56], content_byte[127:120], error_code[129:128], zeros
	output logic [ccpp_pkg::TDATA_W-1:0] m_tdata,
	output logic [1:0]                   m_tuser,  // kind[1:0]
	output logic                         m_tlast   // pool_last
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           start_s1;
	logic           room;
	logic           take;
	logic           res_valid;
	ccpp_pkg::res_t res;

	assign take = valid_s1 && room;

	ccpp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.start_s1 (start_s1)
	);

	ccpp_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.byte_s1   (byte_s1),
		.start_s1  (start_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ccpp_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res        (res),
		.step_valid (valid_s1),
		.room       (room),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

[hw/rtl/ccpp_checker.sv]
// ----------------------------------------------------------------------------
// Constant pool parser checker
// Port-level checks on the result stream of the parser.
// ----------------------------------------------------------------------------
module ccpp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [ccpp_pkg::TDATA_W-1:0] m_tdata,
	input logic [1:0]                   m_tuser,
	input logic                         m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result request changed while stalled");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ccpp_pkg::KIND_ERROR |->
			m_tlast && m_tdata[129:128] != ccpp_pkg::ERR_NONE)
		else $error("error result without pool end or code");

	a_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ccpp_pkg::KIND_ERROR |-> m_tdata[129:128] == ccpp_pkg::ERR_NONE)
		else $error("error code on a non-error result");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ccpp_pkg::KIND_EMPTY |-> m_tlast && m_tdata[15:0] == 16'd0)
		else $error("empty pool result malformed");

	a_no_input_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !$past(s_tvalid && s_tready) |=> !m_tvalid)
		else $error("result without a pending request");

endmodule

bind class_constant_pool_parser_unit ccpp_checker u_ccpp_checker (.*);

[sim/class_constant_pool_parser_unit_test.sv]
// ----------------------------------------------------------------------------
// Constant pool parser testbench
// Streams constant pool byte sequences into the parser and predicts every
// record, Utf8 content byte, empty-pool marker and error that they cause.
// Each record taken from the output is checked field by field. Both sides
// idle at random, the receiver once holds off for a long stretch, and the
// sender pauses between phases until every predicted record has arrived.
// ----------------------------------------------------------------------------
module class_constant_pool_parser_unit_test;
	import ccpp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;

	typedef enum logic [2:0] {P_IDLE, P_COUNT_LO, P_TAG, P_FIELDS, P_UTF8} parse_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} pool_byte_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = 8'd0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	pool_byte_t          byte_stream[$];
	res_t                pending_results[$];
	int                  queued = 0;
	int                  sent_cnt = 0;
	int                  err_cnt = 0;
	int                  idle_max = 0;
	int                  tx_gap = 0;
	int                  rx_wait = 0;
	int                  hold_left = 0;
	logic                hold_flip = 1'b0;
	logic                hold_seen = 1'b0;
	int                  still = 0;

	parse_phase_t        ph = P_IDLE;
	logic [15:0]         pool_size = 16'd0;
	logic [15:0]         slot_ctr = 16'd1;
	logic [7:0]          cur_tag = 8'd0;
	logic [3:0]          fcount = 4'd0;
	logic [63:0]         acc = 64'd0;
	logic [15:0]         utf_left = 16'd0;

	class_constant_pool_parser_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic int field_bytes(input logic [7:0] tag);
		int n;
		case (tag)
			TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHODTYPE: n = 2;
			TAG_METHODHANDLE: n = 3;
			TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_IFACEREF,
			TAG_NAMEANDTYPE, TAG_INVOKEDYNAMIC: n = 4;
			TAG_LONG, TAG_DOUBLE: n = 8;
			default: n = 0;
		endcase
		return n;
	endfunction

	function automatic logic takes_two(input logic [7:0] tag);
		return (tag == TAG_LONG) || (tag == TAG_DOUBLE);
	endfunction

	function automatic res_t error_record(input logic [1:0] code, input logic [15:0] slot,
			input logic [7:0] tag);
		res_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.slot = slot;
		r.entry_tag = tag;
		r.error_code = code;
		r.pool_last = 1'b1;
		ph = P_IDLE;
		return r;
	endfunction

	// Steps past the finished entry and tells whether the pool is complete.
	function automatic logic close_entry();
		logic [16:0] nxt;
		nxt = {1'b0, slot_ctr} + (takes_two(cur_tag) ? 17'd2 : 17'd1);
		slot_ctr = nxt[15:0];
		if (nxt >= {1'b0, pool_size}) begin
			ph = P_IDLE;
			return 1'b1;
		end
		ph = P_TAG;
		return 1'b0;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic st);
		res_t r;
		r = '0;
		if (st) begin
			ph = P_COUNT_LO;
			pool_size = {b, 8'h00};
			slot_ctr = 16'd1;
			cur_tag = 8'd0;
			fcount = 4'd0;
			acc = 64'd0;
			utf_left = 16'd0;
		end else begin
			case (ph)
				P_COUNT_LO: begin
					pool_size[7:0] = b;
					slot_ctr = 16'd1;
					if (pool_size == 16'd0) begin
						pending_results.push_back(error_record(ERR_POOL_SIZE, 16'd0, 8'd0));
					end else if (pool_size == 16'd1) begin
						r.kind = KIND_EMPTY;
						r.pool_last = 1'b1;
						ph = P_IDLE;
						pending_results.push_back(r);
					end else begin
						ph = P_TAG;
					end
				end
				P_TAG: begin
					cur_tag = b;
					if (field_bytes(b) == 0) begin
						pending_results.push_back(error_record(ERR_BAD_TAG, slot_ctr, b));
					end else if (takes_two(b) && ({1'b0, slot_ctr} + 17'd1 >= {1'b0, pool_size})) begin
						pending_results.push_back(error_record(ERR_POOL_SIZE, slot_ctr, b));
					end else begin
						fcount = 4'd0;
						acc = 64'd0;
						ph = P_FIELDS;
					end
				end
				P_FIELDS: begin
					acc = {acc[55:0], b};
					fcount = fcount + 4'd1;
					if (int'(fcount) >= field_bytes(cur_tag)) begin
						r.kind = KIND_ENTRY;
						r.slot = slot_ctr;
						r.entry_tag = cur_tag;
						case (cur_tag)
							TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHODTYPE: r.first_index = acc[15:0];
							TAG_INTEGER, TAG_FLOAT: r.raw_value = {32'd0, acc[31:0]};
							TAG_LONG, TAG_DOUBLE: r.raw_value = acc;
							default: begin
								r.first_index = acc[31:16];
								r.second_index = acc[15:0];
							end
						endcase
						if (cur_tag == TAG_UTF8 && acc[15:0] != 16'd0) begin
							utf_left = acc[15:0];
							ph = P_UTF8;
						end else begin
							r.pool_last = close_entry();
						end
						pending_results.push_back(r);
					end
				end
				P_UTF8: begin
					r.kind = KIND_UTF8;
					r.slot = slot_ctr;
					r.entry_tag = cur_tag;
					r.content_byte = b;
					utf_left = utf_left - 16'd1;
					if (utf_left == 16'd0)
						r.pool_last = close_entry();
					pending_results.push_back(r);
				end
				default: ph = P_IDLE;
			endcase
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
		err_cnt++;
	endtask

	task automatic push_item(input logic [7:0] b, input logic st);
		pool_byte_t it;
		it.data = b;
		it.start = st;
		byte_stream.push_back(it);
		queued++;
	endtask

	function automatic logic [7:0] pick_tag();
		logic [7:0] t;
		case ($urandom_range(13, 0))
			0: t = TAG_UTF8;
			1: t = TAG_INTEGER;
			2: t = TAG_FLOAT;
			3: t = TAG_LONG;
			4: t = TAG_DOUBLE;
			5: t = TAG_CLASS;
			6: t = TAG_STRING;
			7: t = TAG_FIELDREF;
			8: t = TAG_METHODREF;
			9: t = TAG_IFACEREF;
			10: t = TAG_NAMEANDTYPE;
			11: t = TAG_METHODHANDLE;
			12: t = TAG_METHODTYPE;
			default: t = TAG_INVOKEDYNAMIC;
		endcase
		return t;
	endfunction

	task automatic push_entry(input logic [7:0] tag, input int utf_len);
		int nb;
		push_item(tag, 1'b0);
		if (tag == TAG_UTF8) begin
			push_item(utf_len[15:8], 1'b0);
			push_item(utf_len[7:0], 1'b0);
			repeat (utf_len) push_item(8'($urandom_range(255, 0)), 1'b0);
		end else begin
			nb = field_bytes(tag);
			repeat (nb) push_item(8'($urandom_range(255, 0)), 1'b0);
		end
	endtask

	// A pool with random entries; it stops early after max_entries, on an
	// unknown tag, or on a two-slot entry placed at the last slot.
	task automatic push_pool(input int count, input int max_entries);
		int slot;
		int n;
		int len;
		logic [7:0] tag;
		push_item(count[15:8], 1'b1);
		push_item(count[7:0], 1'b0);
		slot = 1;
		n = 0;
		while (slot < count && n < max_entries) begin
			if ($urandom_range(39, 0) == 0) begin
				do tag = 8'($urandom_range(255, 0)); while (field_bytes(tag) != 0);
				push_item(tag, 1'b0);
				break;
			end
			tag = pick_tag();
			if (takes_two(tag) && slot + 1 >= count) begin
				if ($urandom_range(7, 0) == 0) begin
					push_item(tag, 1'b0);
					break;
				end
				tag = TAG_CLASS;
			end
			len = ($urandom_range(15, 0) == 0) ? $urandom_range(60, 0) : $urandom_range(6, 0);
			push_entry(tag, len);
			slot += takes_two(tag) ? 2 : 1;
			n++;
		end
	endtask

	task automatic wait_drained();
		while (sent_cnt != queued || pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		pool_byte_t nxt;
		logic offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'd0;
			s_tuser <= 1'b0;
			tx_gap = 0;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata, s_tuser);
				sent_cnt++;
				tx_gap = $urandom_range(idle_max, 0);
				offer = 1'b0;
			end
			if (!offer) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (byte_stream.size() != 0) begin
					nxt = byte_stream.pop_front();
					s_tdata <= nxt.data;
					s_tuser <= nxt.start;
					offer = 1'b1;
				end
			end
			s_tvalid <= offer;
		end
	end

	always @(posedge clk or negedge arst_n) begin : receive
		res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
			hold_left = 0;
			hold_seen = hold_flip;
		end else begin
			if (m_tvalid === 1'b1 && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with none expected", m_tdata[63:0], 64'd0);
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.kind)
						report_mismatch("kind", 64'(m_tuser), 64'(want.kind));
					if (m_tdata[15:0] !== want.slot)
						report_mismatch("slot", 64'(m_tdata[15:0]), 64'(want.slot));
					if (m_tdata[23:16] !== want.entry_tag)
						report_mismatch("entry_tag", 64'(m_tdata[23:16]), 64'(want.entry_tag));
					if (m_tdata[39:24] !== want.first_index)
						report_mismatch("first_index", 64'(m_tdata[39:24]),
							64'(want.first_index));
					if (m_tdata[55:40] !== want.second_index)
						report_mismatch("second_index", 64'(m_tdata[55:40]),
							64'(want.second_index));
					if (m_tdata[119:56] !== want.raw_value)
						report_mismatch("raw_value", m_tdata[119:56], want.raw_value);
					if (m_tdata[127:120] !== want.content_byte)
						report_mismatch("content_byte", 64'(m_tdata[127:120]),
							64'(want.content_byte));
					if (m_tdata[129:128] !== want.error_code)
						report_mismatch("error_code", 64'(m_tdata[129:128]),
							64'(want.error_code));
					if (m_tdata[TDATA_W-1:130] !== '0)
						report_mismatch("padding", 64'(m_tdata[TDATA_W-1:130]), 64'd0);
					if (m_tlast !== want.pool_last)
						report_mismatch("pool_last", 64'(m_tlast), 64'(want.pool_last));
				end
				rx_wait = $urandom_range(idle_max, 0);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			if (hold_seen != hold_flip) begin
				hold_seen = hold_flip;
				hold_left = HOLD_CYCLES;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			m_tready <= (rx_wait == 0) && (hold_left == 0);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready))
			still = 0;
		else
			still++;
		if (still >= WATCHDOG_LIMIT) begin
			$display("class_constant_pool_parser_unit_test: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		int ph_no;
		int mark;
		int pick;
		int n;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		push_item(8'hA5, 1'b0);
		push_item(8'h00, 1'b1);
		push_item(8'h00, 1'b0);
		push_item(8'h00, 1'b1);
		push_item(8'h01, 1'b0);
		push_item(8'h00, 1'b1);
		push_item(8'h02, 1'b0);
		push_item(TAG_LONG, 1'b0);
		push_item(8'hFF, 1'b1);
		push_item(8'hFF, 1'b0);
		push_item(TAG_UTF8, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h00, 1'b1);
		push_item(8'h03, 1'b0);
		push_item(TAG_DOUBLE, 1'b0);
		repeat (8) push_item(8'hFF, 1'b0);
		wait_drained();

		for (ph_no = 0; ph_no < 8; ph_no++) begin
			idle_max = (ph_no % 3 == 1) ? 0 : 5;
			if (ph_no == 2)
				hold_flip = ~hold_flip;
			mark = queued + 190;
			while (queued < mark) begin
				pick = $urandom_range(99, 0);
				if (pick < 75) begin
					push_pool($urandom_range(10, 2), 65535);
				end else if (pick < 85) begin
					push_pool($urandom_range(65535, 2), $urandom_range(6, 0));
				end else if (pick < 92) begin
					push_item(8'($urandom_range(255, 0)), 1'b1);
					n = $urandom_range(12, 1);
					repeat (n) push_item(8'($urandom_range(255, 0)), $urandom_range(29, 0) == 0);
				end else if (pick < 96) begin
					repeat (3) push_item(8'($urandom_range(255, 0)), 1'b0);
				end else begin
					push_pool($urandom_range(1, 0), 65535);
				end
			end
			wait_drained();
		end

		if (err_cnt == 0)
			$display("class_constant_pool_parser_unit_test: done, clean");
		else
			$display("class_constant_pool_parser_unit_test: done, errors");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/ccpp_pkg.sv
hw/rtl/ccpp_in_stage.sv
hw/rtl/ccpp_step.sv
hw/rtl/ccpp_out_stage.sv
hw/rtl/class_constant_pool_parser_unit.sv
hw/rtl/ccpp_checker.sv
sim/class_constant_pool_parser_unit_test.sv
